@@ rtl/lfu_pkg.sv @@
// Shared types, sizes and result struct for the LFU page replacement unit.
// Used by lfu_scan and lfu_page_replacement_unit; no dependencies.
`timescale 1ns / 1ps

package lfu_pkg;

    localparam int NUM_FRAMES  = 8;
    localparam int MAX_PAGES   = 256;
    localparam int COUNT_WIDTH = 16;

    localparam int PAGE_W   = 8;
    localparam int FRAME_W  = 3;
    localparam int TOTAL_W  = 16;
    localparam int FIU_W    = 4;

    localparam int FRAME_AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int FRAME_CW = $clog2(NUM_FRAMES + 1);
    localparam int CNT_AW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

    typedef logic [PAGE_W-1:0]      page_t;
    typedef logic [FRAME_W-1:0]     frame_out_t;
    typedef logic [FRAME_AW-1:0]    frame_idx_t;
    typedef logic [FRAME_CW-1:0]    frame_cnt_t;
    typedef logic [CNT_AW-1:0]      cnt_addr_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [TOTAL_W-1:0]     total_t;
    typedef logic [FIU_W-1:0]       fiu_t;

    localparam fiu_t   FIU_RESET = fiu_t'(8);
    localparam count_t COUNT_MAX = '1;
    localparam total_t TOTAL_MAX = '1;

    // Outcome of one pass over the active frames
    typedef struct packed {
        logic       hit;
        frame_idx_t hit_idx;
        logic       empty;
        frame_idx_t empty_idx;
        frame_idx_t best_idx;
        page_t      best_page;
    } scan_result_t;

endpackage

@@ rtl/lfu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
`timescale 1ns / 1ps

module lfu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/lfu_scan.sv @@
// Shared compare unit: one frame per cycle, hit / first-empty search and
// least-count victim selection. Depends on lfu_pkg.
`timescale 1ns / 1ps

module lfu_scan (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  clr,
    input  logic                  issue_en,
    input  lfu_pkg::frame_idx_t   issue_idx,
    input  logic                  issue_vld,
    input  lfu_pkg::page_t        issue_page,
    input  logic                  issue_cnt_vld,
    input  lfu_pkg::page_t        pg,
    input  lfu_pkg::count_t       rd_count,
    output lfu_pkg::scan_result_t res
);

    logic                cmp_en_reg;
    lfu_pkg::frame_idx_t cmp_idx_reg;
    lfu_pkg::page_t      cmp_page_reg;
    logic                cmp_cvld_reg;
    logic                hit_reg;
    lfu_pkg::frame_idx_t hit_idx_reg;
    logic                empty_reg;
    lfu_pkg::frame_idx_t empty_idx_reg;
    lfu_pkg::count_t     best_count_reg;
    lfu_pkg::frame_idx_t best_idx_reg;
    lfu_pkg::page_t      best_page_reg;
    lfu_pkg::count_t     cmp_count;
    logic                take_best;

    // never-written counters read as zero
    assign cmp_count = cmp_cvld_reg ? rd_count : '0;
    assign take_best = cmp_en_reg && ((cmp_idx_reg == '0) || (cmp_count < best_count_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_en_reg <= 1'b0;
            hit_reg    <= 1'b0;
            empty_reg  <= 1'b0;
        end
        else if (clr)
        begin
            cmp_en_reg <= 1'b0;
            hit_reg    <= 1'b0;
            empty_reg  <= 1'b0;
        end
        else
        begin
            cmp_en_reg <= issue_en;
            if (issue_en && !hit_reg && issue_vld && (issue_page == pg))
            begin
                hit_reg <= 1'b1;
            end
            if (issue_en && !empty_reg && !issue_vld)
            begin
                empty_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= issue_idx;
        cmp_page_reg <= issue_page;
        cmp_cvld_reg <= issue_cnt_vld;
        if (issue_en && !hit_reg && issue_vld && (issue_page == pg))
        begin
            hit_idx_reg <= issue_idx;
        end
        if (issue_en && !empty_reg && !issue_vld)
        begin
            empty_idx_reg <= issue_idx;
        end
        if (take_best)
        begin
            best_count_reg <= cmp_count;
            best_idx_reg   <= cmp_idx_reg;
            best_page_reg  <= cmp_page_reg;
        end
    end

    assign res.hit       = hit_reg;
    assign res.hit_idx   = hit_idx_reg;
    assign res.empty     = empty_reg;
    assign res.empty_idx = empty_idx_reg;
    assign res.best_idx  = best_idx_reg;
    assign res.best_page = best_page_reg;

endmodule

@@ rtl/lfu_page_replacement_unit.sv @@
// Sequence: from start to done the unit scans the active frames one frame per
//   cycle through the shared compare unit, then does the read-modify-write of
//   the use counter in the counter RAM.
// A new command is accepted only while idle; busy is high until the result.
// Results are strobed on done for one cycle; the receiver cannot stall.
// Reset (rst_n low, async): frames empty, use counts and fault total zero,
//   frames_in_use = 8; no clearing pass, counters carry per-entry valid bits.
`timescale 1ns / 1ps

module lfu_page_replacement_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration: frames_in_use
    input  logic                  cfg_we,
    input  lfu_pkg::fiu_t         cfg_wdata,
    // command
    input  logic                  start,
    output logic                  busy,
    input  lfu_pkg::page_t        page,
    // result
    output logic                  done,
    output logic                  fault,
    output lfu_pkg::frame_out_t   frame_index,
    output logic                  evicted_valid,
    output lfu_pkg::page_t        evicted_page,
    output lfu_pkg::total_t       total_faults
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RDCNT,
        ST_WRCNT
    } state_t;

    state_t                state_reg;
    lfu_pkg::fiu_t         fiu_reg;
    lfu_pkg::frame_cnt_t   j_reg;
    lfu_pkg::frame_cnt_t   act_reg;
    lfu_pkg::page_t        pg_reg;
    logic                  cv_pg_reg;
    logic [lfu_pkg::NUM_FRAMES-1:0] frame_valid_reg;
    lfu_pkg::page_t        frame_page_reg [lfu_pkg::NUM_FRAMES];
    logic [lfu_pkg::MAX_PAGES-1:0]  cnt_vld_reg;
    lfu_pkg::total_t       total_reg;

    logic                  done_reg;
    logic                  fault_reg;
    lfu_pkg::frame_out_t   frame_index_reg;
    logic                  evicted_valid_reg;
    lfu_pkg::page_t        evicted_page_reg;

    lfu_pkg::frame_cnt_t   act_next;
    lfu_pkg::frame_idx_t   j_idx;
    lfu_pkg::page_t        scan_page;
    lfu_pkg::cnt_addr_t    scan_addr;
    lfu_pkg::cnt_addr_t    pg_addr;
    lfu_pkg::cnt_addr_t    ram_raddr;
    lfu_pkg::count_t       ram_rdata;
    lfu_pkg::count_t       cur_count;
    lfu_pkg::count_t       new_count;
    logic                  issue_en;
    logic                  ram_we;
    lfu_pkg::frame_idx_t   slot;
    lfu_pkg::scan_result_t scan_res;

    // Clamp the frame count: zero acts as one, above NUM_FRAMES acts as NUM_FRAMES
    always_comb
    begin
        if (fiu_reg == '0)
        begin
            act_next = lfu_pkg::frame_cnt_t'(1);
        end
        else if (lfu_pkg::frame_cnt_t'(fiu_reg) > lfu_pkg::frame_cnt_t'(lfu_pkg::NUM_FRAMES))
        begin
            act_next = lfu_pkg::frame_cnt_t'(lfu_pkg::NUM_FRAMES);
        end
        else
        begin
            act_next = lfu_pkg::frame_cnt_t'(fiu_reg);
        end
    end

    // Scan side: one frame per cycle, count RAM read issued for its page
    assign j_idx     = j_reg[lfu_pkg::FRAME_AW-1:0];
    assign scan_page = frame_page_reg[j_idx];
    assign scan_addr = lfu_pkg::cnt_addr_t'(scan_page);
    // page modulo MAX_PAGES picks the counter
    assign pg_addr   = lfu_pkg::cnt_addr_t'(pg_reg);
    assign issue_en  = (state_reg == ST_SCAN) && (j_reg < act_reg);
    assign ram_raddr = (state_reg == ST_SCAN) ? scan_addr : pg_addr;

    // Counter update for the referenced page, saturating
    assign cur_count = cv_pg_reg ? ram_rdata : '0;
    assign new_count = (cur_count == lfu_pkg::COUNT_MAX) ? cur_count : cur_count + 1'b1;
    assign ram_we    = (state_reg == ST_WRCNT);

    // Frame that holds the page after this beat
    always_comb
    begin
        if (scan_res.hit)
        begin
            slot = scan_res.hit_idx;
        end
        else if (scan_res.empty)
        begin
            slot = scan_res.empty_idx;
        end
        else
        begin
            slot = scan_res.best_idx;
        end
    end

    lfu_ram #(
        .WIDTH (lfu_pkg::COUNT_WIDTH),
        .DEPTH (lfu_pkg::MAX_PAGES)
    ) u_count_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pg_addr),
        .wdata (new_count),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lfu_scan u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .clr           (start && !busy),
        .issue_en      (issue_en),
        .issue_idx     (j_idx),
        .issue_vld     (frame_valid_reg[j_idx]),
        .issue_page    (scan_page),
        .issue_cnt_vld (cnt_vld_reg[scan_addr]),
        .pg            (pg_reg),
        .rd_count      (ram_rdata),
        .res           (scan_res)
    );

    // Sequencer, control state and registered result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            fiu_reg           <= lfu_pkg::FIU_RESET;
            j_reg             <= '0;
            act_reg           <= lfu_pkg::frame_cnt_t'(1);
            frame_valid_reg   <= '0;
            cnt_vld_reg       <= '0;
            total_reg         <= '0;
            done_reg          <= 1'b0;
            fault_reg         <= 1'b0;
            frame_index_reg   <= '0;
            evicted_valid_reg <= 1'b0;
            evicted_page_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                fiu_reg <= cfg_wdata;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        j_reg     <= '0;
                        act_reg   <= act_next;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    // a final step with j_reg at act_reg lets the last count reach the compare
                    if (j_reg == act_reg)
                    begin
                        state_reg <= ST_RDCNT;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_RDCNT:
                begin
                    state_reg <= ST_WRCNT;
                end
                ST_WRCNT:
                begin
                    cnt_vld_reg[pg_addr] <= 1'b1;
                    done_reg             <= 1'b1;
                    fault_reg            <= !scan_res.hit;
                    frame_index_reg      <= lfu_pkg::frame_out_t'(slot);
                    evicted_valid_reg    <= !scan_res.hit && !scan_res.empty;
                    evicted_page_reg     <= (!scan_res.hit && !scan_res.empty) ?
                                            scan_res.best_page : '0;
                    if (!scan_res.hit)
                    begin
                        frame_valid_reg[slot] <= 1'b1;
                        if (total_reg != lfu_pkg::TOTAL_MAX)
                        begin
                            total_reg <= total_reg + 1'b1;
                        end
                    end
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload: latch the page on accept, fill the chosen frame on a fault
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            pg_reg <= page;
        end
        if (state_reg == ST_RDCNT)
        begin
            cv_pg_reg <= cnt_vld_reg[pg_addr];
        end
        if ((state_reg == ST_WRCNT) && !scan_res.hit)
        begin
            frame_page_reg[slot] <= pg_reg;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign fault         = fault_reg;
    assign frame_index   = frame_index_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign total_faults  = total_reg;

`ifndef ASSERT_OFF
    // A beat passes through scan, count read and count write, so done never repeats back to back
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobed in consecutive cycles");

    // An eviction only happens on a fault
    a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (done && evicted_valid) |-> fault)
        else $error("eviction reported on a hit");

    // Frames never go back to empty once filled
    a_frames_fill: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(frame_valid_reg) >= $countones($past(frame_valid_reg))))
        else $error("frame valid count dropped");

    // An accepted command raises busy
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");
`endif

endmodule
